// ===== rtl/hfv_pkg.sv =====
package hfv_pkg;

    // cell kinds (code 3 behaves as an interior cell)
    localparam logic [1:0] CELL_INTERIOR = 2'd0;
    localparam logic [1:0] CELL_LEFT     = 2'd1;
    localparam logic [1:0] CELL_RIGHT    = 2'd2;

    // boundary condition kinds (code 3 behaves as an insulated wall)
    localparam logic [1:0] BC_TEMP = 2'd0;
    localparam logic [1:0] BC_FLUX = 2'd1;
    localparam logic [1:0] BC_CONV = 2'd2;

    // register indexes, byte address = 8 * index
    localparam logic [2:0] REG_CELL_SIZE   = 3'd0;
    localparam logic [2:0] REG_TIME_STEP   = 3'd1;
    localparam logic [2:0] REG_LEFT_KIND   = 3'd2;
    localparam logic [2:0] REG_LEFT_VALUE  = 3'd3;
    localparam logic [2:0] REG_LEFT_FILM   = 3'd4;
    localparam logic [2:0] REG_RIGHT_KIND  = 3'd5;
    localparam logic [2:0] REG_RIGHT_VALUE = 3'd6;
    localparam logic [2:0] REG_RIGHT_FILM  = 3'd7;

endpackage

// ===== rtl/heat_fv_tridiag_row_assembly_top.sv =====
// Channel | Signals                                              | Direction
// --------+------------------------------------------------------+----------
// in      | in_valid, in_stall, cell_kind .. previous_temp       | in
// out     | out_valid, out_stall, lower_coef .. rhs              | out
// config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | in/out
//
// One cell per cycle while the output is not stalled.
// Pipeline depth is set by the convection path: two chained bit-per-stage dividers.
// Reset clears the pipeline valid bits and sets dx = dt = 1.0, other registers to 0.
// A stalled output freezes the whole pipeline; in_stall follows out_valid && out_stall.
module heat_fv_tridiag_row_assembly_top #(
    parameter int VALUE_WIDTH = 48,
    parameter int FRAC_BITS   = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             cell_kind,
    input  logic [VALUE_WIDTH-2:0] density,
    input  logic [VALUE_WIDTH-2:0] heat_capacity,
    input  logic [VALUE_WIDTH-2:0] conductivity_here,
    input  logic [VALUE_WIDTH-2:0] conductivity_left,
    input  logic [VALUE_WIDTH-2:0] conductivity_right,
    input  logic signed [VALUE_WIDTH-1:0] previous_temp,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [VALUE_WIDTH-1:0] lower_coef,
    output logic signed [VALUE_WIDTH-1:0] diag_coef,
    output logic signed [VALUE_WIDTH-1:0] upper_coef,
    output logic signed [VALUE_WIDTH-1:0] rhs,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LO   = (W + 1) / 2;
    localparam int HI   = W - LO;
    localparam int LD   = W + 2;
    localparam int T2   = 4 + LD;
    localparam int T3   = T2 + 1 + LD;
    localparam int OUTP = T3 + 3;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]   kind;
        logic [W-1:0] temp;
        logic [W-2:0] kp;
        logic [W-2:0] kl;
        logic [W-2:0] kr;
    } ctx_t;

    typedef struct packed {
        logic [2*LO-1:0] ll;
        logic [W-1:0]    lh;
        logic [W-1:0]    hl;
        logic [2*HI-1:0] hh;
        logic            neg;
    } pp_t;

    typedef struct packed {
        logic [W-2:0] ap0;
        logic [W-2:0] aw;
        logic [W-2:0] ae;
        logic [W-2:0] gt;
    } div1_t;

    function automatic pp_t mul_pp(input logic [W-1:0] a, input logic [W-1:0] b,
                                   input logic neg);
        pp_t p;
        p.ll  = (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
        p.lh  = W'(a[LO-1:0]) * W'(b[W-1:LO]);
        p.hl  = W'(a[W-1:LO]) * W'(b[LO-1:0]);
        p.hh  = (2*HI)'(a[W-1:LO]) * (2*HI)'(b[W-1:LO]);
        p.neg = neg;
        return p;
    endfunction

    function automatic logic [W-1:0] mul_fin(input pp_t p);
        logic [2*W:0] sum;
        logic [2*W:0] qv;
        logic [2*W:0] cap;
        logic [W-1:0] m;
        sum = (2*W+1)'(p.ll) + ((2*W+1)'(p.lh) << LO) + ((2*W+1)'(p.hl) << LO)
            + ((2*W+1)'(p.hh) << (2*LO)) + ((2*W+1)'(1) << (F-1));
        qv  = sum >> F;
        cap = p.neg ? ((2*W+1)'(1) << (W-1)) : (((2*W+1)'(1) << (W-1)) - 1);
        m   = (qv > cap) ? W'(cap) : W'(qv);
        return p.neg ? (W'(0) - m) : m;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (W'(0) - v) : v;
    endfunction

    function automatic logic [W-1:0] sneg(input logic [W-1:0] v);
        return (v == MINV) ? MAXV : (W'(0) - v);
    endfunction

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? MINV : MAXV;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sum3(input logic [W-2:0] a, input logic [W-2:0] b,
                                          input logic [W-2:0] c);
        logic [W:0] s;
        s = (W+1)'(a) + (W+1)'(b) + (W+1)'(c);
        return (s > (W+1)'(MAXV)) ? MAXV : W'(s);
    endfunction

    // configuration
    logic [W-2:0] dx_reg, dt_reg, lfilm_reg, rfilm_reg;
    logic [1:0]   lbck_reg, rbck_reg;
    logic [W-1:0] lval_reg, rval_reg;
    logic [2:0]   cfg_idx;
    logic         cfg_wr;

    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dx_reg    <= (W-1)'(1) << F;
            dt_reg    <= (W-1)'(1) << F;
            lbck_reg  <= '0;
            rbck_reg  <= '0;
            lval_reg  <= '0;
            rval_reg  <= '0;
            lfilm_reg <= '0;
            rfilm_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                hfv_pkg::REG_CELL_SIZE:   dx_reg    <= pwdata[W-2:0];
                hfv_pkg::REG_TIME_STEP:   dt_reg    <= pwdata[W-2:0];
                hfv_pkg::REG_LEFT_KIND:   lbck_reg  <= pwdata[1:0];
                hfv_pkg::REG_LEFT_VALUE:  lval_reg  <= pwdata[W-1:0];
                hfv_pkg::REG_LEFT_FILM:   lfilm_reg <= pwdata[W-2:0];
                hfv_pkg::REG_RIGHT_KIND:  rbck_reg  <= pwdata[1:0];
                hfv_pkg::REG_RIGHT_VALUE: rval_reg  <= pwdata[W-1:0];
                hfv_pkg::REG_RIGHT_FILM:  rfilm_reg <= pwdata[W-2:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            hfv_pkg::REG_CELL_SIZE:   prdata = 64'(dx_reg);
            hfv_pkg::REG_TIME_STEP:   prdata = 64'(dt_reg);
            hfv_pkg::REG_LEFT_KIND:   prdata = 64'(lbck_reg);
            hfv_pkg::REG_LEFT_VALUE:  prdata = 64'(lval_reg);
            hfv_pkg::REG_LEFT_FILM:   prdata = 64'(lfilm_reg);
            hfv_pkg::REG_RIGHT_KIND:  prdata = 64'(rbck_reg);
            hfv_pkg::REG_RIGHT_VALUE: prdata = 64'(rval_reg);
            hfv_pkg::REG_RIGHT_FILM:  prdata = 64'(rfilm_reg);
        endcase
    end

    // pipeline control: everything advances together
    logic            adv;
    logic [OUTP:0]   vld_reg;
    ctx_t            ctx_reg [0:OUTP];

    assign adv      = !(vld_reg[OUTP] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[OUTP-1:0], in_valid};
        end
    end

    logic [W-2:0] rho0_reg, cp0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= '{kind: cell_kind, temp: previous_temp, kp: conductivity_here,
                            kl: conductivity_left, kr: conductivity_right};
            rho0_reg   <= density;
            cp0_reg    <= heat_capacity;
            for (int i = 1; i <= OUTP; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // rho*cp, then *dx; film*dx alongside
    pp_t          m1pp_reg, m2pp_reg, t1pp_reg;
    logic [W-1:0] m1_reg, m2_reg, t1_reg;
    logic [W-2:0] h2;

    assign h2 = (ctx_reg[2].kind == hfv_pkg::CELL_RIGHT) ? rfilm_reg : lfilm_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1pp_reg <= mul_pp({1'b0, rho0_reg}, {1'b0, cp0_reg}, 1'b0);
            m1_reg   <= mul_fin(m1pp_reg);
            m2pp_reg <= mul_pp(m1_reg, {1'b0, dx_reg}, 1'b0);
            t1pp_reg <= mul_pp({1'b0, h2}, {1'b0, dx_reg}, 1'b0);
            m2_reg   <= mul_fin(m2pp_reg);
            t1_reg   <= mul_fin(t1pp_reg);
        end
    end

    // first divider bank
    logic [W-2:0] ap0_q, aw_q, ae_q, gt_q, t2_q, gc_q;

    hfv_div #(.W(W), .SHIFT(F)) u_div_ap0 (
        .clk(clk), .en(adv), .num(m2_reg), .den(dt_reg), .quo(ap0_q));

    hfv_div #(.W(W), .SHIFT(F-1)) u_div_aw (
        .clk(clk), .en(adv), .num({1'b0, ctx_reg[4].kl} + {1'b0, ctx_reg[4].kp}),
        .den(dx_reg), .quo(aw_q));

    hfv_div #(.W(W), .SHIFT(F-1)) u_div_ae (
        .clk(clk), .en(adv), .num({1'b0, ctx_reg[4].kp} + {1'b0, ctx_reg[4].kr}),
        .den(dx_reg), .quo(ae_q));

    hfv_div #(.W(W), .SHIFT(F+1)) u_div_gt (
        .clk(clk), .en(adv), .num({1'b0, ctx_reg[4].kp}), .den(dx_reg), .quo(gt_q));

    hfv_div #(.W(W), .SHIFT(F-1)) u_div_t2 (
        .clk(clk), .en(adv), .num(t1_reg), .den(ctx_reg[4].kp), .quo(t2_q));

    // convection: g = h / (1 + h*dx/(2k))
    logic [W-2:0] den_reg;
    logic [W-1:0] den_next;
    logic [W-2:0] h_conv;
    div1_t        d1_reg [0:LD];

    assign den_next = (W'(1) << F) + W'(t2_q);
    assign h_conv   = (ctx_reg[T2+1].kind == hfv_pkg::CELL_RIGHT) ? rfilm_reg : lfilm_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg   <= (den_next > MAXV) ? MAXV[W-2:0] : den_next[W-2:0];
            d1_reg[0] <= '{ap0: ap0_q, aw: aw_q, ae: ae_q, gt: gt_q};
            for (int i = 1; i <= LD; i++)
            begin
                d1_reg[i] <= d1_reg[i-1];
            end
        end
    end

    hfv_div #(.W(W), .SHIFT(F)) u_div_gc (
        .clk(clk), .en(adv), .num({1'b0, h_conv}), .den(den_reg), .quo(gc_q));

    // row assembly
    ctx_t         c3, c4;
    div1_t        dv;
    logic [1:0]   bck3, bck4;
    logic [W-1:0] val3, val4;
    logic         end3, end4;
    logic [W-2:0] g3, sel_a, sel_b;

    assign c3    = ctx_reg[T3];
    assign dv    = d1_reg[LD];
    assign end3  = (c3.kind == hfv_pkg::CELL_LEFT) || (c3.kind == hfv_pkg::CELL_RIGHT);
    assign bck3  = (c3.kind == hfv_pkg::CELL_RIGHT) ? rbck_reg : lbck_reg;
    assign val3  = (c3.kind == hfv_pkg::CELL_RIGHT) ? rval_reg : lval_reg;

    always_comb
    begin
        unique case (bck3)
            hfv_pkg::BC_TEMP: g3 = dv.gt;
            hfv_pkg::BC_CONV: g3 = gc_q;
            default:          g3 = '0;
        endcase
        sel_a = (c3.kind == hfv_pkg::CELL_LEFT) ? dv.ae : dv.aw;
        sel_b = end3 ? g3 : dv.ae;
    end

    pp_t          pa_pp_reg, ps_pp_reg;
    logic [W-1:0] diag1_reg, low1_reg, up1_reg;
    logic [W-1:0] diag2_reg, low2_reg, up2_reg, pa_reg, s2_reg;
    logic [W-1:0] s_next, sm;
    logic [W-1:0] lower_reg, diag_reg, upper_reg, rhs_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_pp_reg <= mul_pp({1'b0, dv.ap0}, mag(c3.temp), c3.temp[W-1]);
            ps_pp_reg <= mul_pp({1'b0, g3}, mag(val3), val3[W-1]);
            diag1_reg <= sum3(dv.ap0, sel_a, sel_b);
            low1_reg  <= (c3.kind == hfv_pkg::CELL_LEFT) ? '0 : sneg({1'b0, dv.aw});
            up1_reg   <= (c3.kind == hfv_pkg::CELL_RIGHT) ? '0 : sneg({1'b0, dv.ae});
        end
    end

    assign c4   = ctx_reg[T3+1];
    assign end4 = (c4.kind == hfv_pkg::CELL_LEFT) || (c4.kind == hfv_pkg::CELL_RIGHT);
    assign bck4 = (c4.kind == hfv_pkg::CELL_RIGHT) ? rbck_reg : lbck_reg;
    assign val4 = (c4.kind == hfv_pkg::CELL_RIGHT) ? rval_reg : lval_reg;
    assign sm   = mul_fin(ps_pp_reg);

    always_comb
    begin
        unique case (bck4)
            hfv_pkg::BC_TEMP: s_next = sm;
            hfv_pkg::BC_CONV: s_next = sm;
            hfv_pkg::BC_FLUX: s_next = sneg(val4);
            default:          s_next = '0;
        endcase
        if (!end4)
        begin
            s_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg    <= mul_fin(pa_pp_reg);
            s2_reg    <= s_next;
            diag2_reg <= diag1_reg;
            low2_reg  <= low1_reg;
            up2_reg   <= up1_reg;
            lower_reg <= low2_reg;
            diag_reg  <= diag2_reg;
            upper_reg <= up2_reg;
            rhs_reg   <= sadd(s2_reg, pa_reg);
        end
    end

    assign out_valid  = vld_reg[OUTP];
    assign lower_coef = lower_reg;
    assign diag_coef  = diag_reg;
    assign upper_coef = upper_reg;
    assign rhs        = rhs_reg;

    a_left_lower: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUTP] && (ctx_reg[OUTP].kind == hfv_pkg::CELL_LEFT) |-> lower_reg == '0)
        else $error("left end row with nonzero lower coefficient");

    a_right_upper: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUTP] && (ctx_reg[OUTP].kind == hfv_pkg::CELL_RIGHT) |-> upper_reg == '0)
        else $error("right end row with nonzero upper coefficient");

    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUTP] |-> !diag_reg[W-1])
        else $error("negative diagonal coefficient");

    a_offdiag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[OUTP] |-> (lower_reg == '0 || lower_reg[W-1]) &&
                          (upper_reg == '0 || upper_reg[W-1]))
        else $error("positive off-diagonal coefficient");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== rtl/hfv_div.sv =====
// Pipelined restoring divider: quo = sat(round(num * 2^SHIFT / den)).
// One quotient bit per stage, one operation per cycle while en is high.
module hfv_div #(
    parameter int W     = 48,
    parameter int SHIFT = 24
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] num,
    input  logic [W-2:0] den,
    output logic [W-2:0] quo
);

    localparam int NW = W + SHIFT;

    typedef struct packed {
        logic [W-1:0] r;
        logic [W-1:0] q;
        logic [W-1:0] low;
        logic [W-2:0] d;
        logic         ovf;
        logic         nz;
    } step_t;

    step_t          st_reg  [0:W];
    step_t          st_next [0:W];
    logic [NW-1:0]  nshift;
    logic [W-2:0]   quo_reg;
    logic [W-1:0]   diff;
    logic           rnd_up;
    logic [W:0]     qr;

    // setup: quotient needs more than W bits when the upper part already reaches den
    always_comb
    begin
        nshift          = {num, {SHIFT{1'b0}}};
        st_next[0].r    = W'(nshift[NW-1:W]);
        st_next[0].q    = '0;
        st_next[0].low  = nshift[W-1:0];
        st_next[0].d    = den;
        st_next[0].ovf  = (NW'(nshift[NW-1:W]) >= NW'(den));
        st_next[0].nz   = (num != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_next[0];
        end
    end

    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W-1:0] rr;
        logic         ge;

        always_comb
        begin
            rr         = {st_reg[k-1].r[W-2:0], st_reg[k-1].low[W-k]};
            ge         = (rr >= {1'b0, st_reg[k-1].d});
            st_next[k] = st_reg[k-1];
            st_next[k].r = ge ? (rr - {1'b0, st_reg[k-1].d}) : rr;
            st_next[k].q = {st_reg[k-1].q[W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // round half away from zero, then saturate
    always_comb
    begin
        diff   = {1'b0, st_reg[W].d} - st_reg[W].r;
        rnd_up = (st_reg[W].r >= diff);
        qr     = {1'b0, st_reg[W].q} + (W+1)'(rnd_up);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!st_reg[W].nz)
            begin
                quo_reg <= '0;
            end
            else if (st_reg[W].ovf || (qr > (W+1)'({(W-1){1'b1}})))
            begin
                quo_reg <= {(W-1){1'b1}};
            end
            else
            begin
                quo_reg <= qr[W-2:0];
            end
        end
    end

    assign quo = quo_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int VW = 48;
    localparam int FB = 24;

    // boundary code with no condition attached: acts as an insulated wall
    localparam logic [1:0] BC_UNUSED = 2'd3;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [1:0]           kind;
        logic [VW-2:0]        rho;
        logic [VW-2:0]        cp;
        logic [VW-2:0]        kp;
        logic [VW-2:0]        kl;
        logic [VW-2:0]        kr;
        logic signed [VW-1:0] temp;
    } cell_t;

    typedef struct {
        logic [VW-1:0] lower;
        logic [VW-1:0] diag;
        logic [VW-1:0] upper;
        logic [VW-1:0] rhs;
    } row_t;

    class row_scoreboard;
        localparam wide_t MAXV = (wide_t'(1) <<< (VW - 1)) - 1;
        localparam wide_t HUGE = wide_t'(1) <<< 100;

        wide_t dx, dt;
        wide_t bc_kind[2], bc_value[2], bc_film[2];
        row_t  rows_due[$];
        int    errors;

        function new();
            dx = wide_t'(1) <<< FB;
            dt = wide_t'(1) <<< FB;
            for (int i = 0; i < 2; i++)
            begin
                bc_kind[i] = 0;
                bc_value[i] = 0;
                bc_film[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                hfv_pkg::REG_CELL_SIZE:   dx = wide_t'(v[VW-2:0]);
                hfv_pkg::REG_TIME_STEP:   dt = wide_t'(v[VW-2:0]);
                hfv_pkg::REG_LEFT_KIND:   bc_kind[0] = wide_t'(v[1:0]);
                hfv_pkg::REG_LEFT_VALUE:  bc_value[0] = wide_t'($signed(v[VW-1:0]));
                hfv_pkg::REG_LEFT_FILM:   bc_film[0] = wide_t'(v[VW-2:0]);
                hfv_pkg::REG_RIGHT_KIND:  bc_kind[1] = wide_t'(v[1:0]);
                hfv_pkg::REG_RIGHT_VALUE: bc_value[1] = wide_t'($signed(v[VW-1:0]));
                hfv_pkg::REG_RIGHT_FILM:  bc_film[1] = wide_t'(v[VW-2:0]);
                default: ;
            endcase
        endfunction

        function wide_t clip(bit neg, wide_t m);
            if (neg)
                return (m > MAXV + 1) ? -(MAXV + 1) : -m;
            return (m > MAXV) ? MAXV : m;
        endfunction

        function wide_t add_sat(wide_t a, wide_t b);
            wide_t s;
            s = a + b;
            if (s > MAXV) return MAXV;
            if (s < -(MAXV + 1)) return -(MAXV + 1);
            return s;
        endfunction

        function wide_t neg_sat(wide_t a);
            return (a == -(MAXV + 1)) ? MAXV : -a;
        endfunction

        // product rounded half away from zero
        function wide_t qmul(wide_t a, wide_t b);
            bit    neg;
            wide_t m;
            neg = (a < 0) != (b < 0);
            m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
            return clip(neg, (m + (wide_t'(1) <<< (FB - 1))) >>> FB);
        endfunction

        // round(n * 2^s / d); zero divisor saturates a nonzero n
        function wide_t qdiv(wide_t n, wide_t d, int s);
            wide_t q, r;
            if (d == 0)
                return (n != 0) ? clip(0, HUGE) : 0;
            q = (n <<< s) / d;
            r = (n <<< s) % d;
            if (2 * r >= d) q = q + 1;
            return clip(0, q);
        endfunction

        function void note_cell(cell_t c);
            wide_t ap0, a, aw, ae, g, s, val, h, t1, t2, den, tp;
            wide_t kp, kl, kr;
            int    side;
            row_t  r;
            kp = wide_t'(c.kp);
            kl = wide_t'(c.kl);
            kr = wide_t'(c.kr);
            tp = wide_t'(c.temp);
            ap0 = qmul(qmul(wide_t'(c.rho), wide_t'(c.cp)), dx);
            ap0 = qdiv(ap0, dt, FB);
            if (c.kind == hfv_pkg::CELL_LEFT || c.kind == hfv_pkg::CELL_RIGHT)
            begin
                side = (c.kind == hfv_pkg::CELL_LEFT) ? 0 : 1;
                a = qdiv(kp + (side == 0 ? kr : kl), dx, FB - 1);
                val = bc_value[side];
                g = 0;
                s = 0;
                if (bc_kind[side] == hfv_pkg::BC_TEMP)
                begin
                    g = qdiv(kp, dx, FB + 1);
                    s = qmul(g, val);
                end
                else if (bc_kind[side] == hfv_pkg::BC_FLUX)
                    s = neg_sat(val);
                else if (bc_kind[side] == hfv_pkg::BC_CONV)
                begin
                    // half-cell conduction in series with the film
                    h = bc_film[side];
                    t1 = qmul(h, dx);
                    t2 = qdiv(t1, kp, FB - 1);
                    den = add_sat(wide_t'(1) <<< FB, t2);
                    g = qdiv(h, den, FB);
                    s = qmul(g, val);
                end
                r.lower = (side == 0) ? '0 : VW'(neg_sat(a));
                r.upper = (side == 0) ? VW'(neg_sat(a)) : '0;
                r.diag = VW'(add_sat(add_sat(ap0, a), g));
                r.rhs = VW'(add_sat(s, qmul(ap0, tp)));
            end
            else
            begin
                aw = qdiv(kl + kp, dx, FB - 1);
                ae = qdiv(kp + kr, dx, FB - 1);
                r.lower = VW'(neg_sat(aw));
                r.upper = VW'(neg_sat(ae));
                r.diag = VW'(add_sat(add_sat(ap0, aw), ae));
                r.rhs = VW'(qmul(ap0, tp));
            end
            rows_due.push_back(r);
        endfunction

        function void check_row(row_t got);
            row_t exp_row;
            if (rows_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected row: %h %h %h %h",
                             got.lower, got.diag, got.upper, got.rhs);
                return;
            end
            exp_row = rows_due.pop_front();
            if (exp_row.lower !== got.lower || exp_row.diag !== got.diag ||
                exp_row.upper !== got.upper || exp_row.rhs !== got.rhs)
            begin
                errors++;
                if (errors <= 10)
                    $display("row mismatch: exp %h %h %h %h got %h %h %h %h",
                             exp_row.lower, exp_row.diag, exp_row.upper, exp_row.rhs,
                             got.lower, got.diag, got.upper, got.rhs);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           cell_kind;
    logic [VW-2:0]        density;
    logic [VW-2:0]        heat_capacity;
    logic [VW-2:0]        conductivity_here;
    logic [VW-2:0]        conductivity_left;
    logic [VW-2:0]        conductivity_right;
    logic signed [VW-1:0] previous_temp;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [VW-1:0] lower_coef;
    logic signed [VW-1:0] diag_coef;
    logic signed [VW-1:0] upper_coef;
    logic signed [VW-1:0] rhs;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [5:0]           paddr;
    logic [63:0]          pwdata;
    logic [63:0]          prdata;
    logic                 pready;

    row_scoreboard sb;
    bit calm;
    bit want_hold;

    heat_fv_tridiag_row_assembly_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cell_kind(cell_kind),
        .density(density),
        .heat_capacity(heat_capacity),
        .conductivity_here(conductivity_here),
        .conductivity_left(conductivity_left),
        .conductivity_right(conductivity_right),
        .previous_temp(previous_temp),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .lower_coef(lower_coef),
        .diag_coef(diag_coef),
        .upper_coef(upper_coef),
        .rhs(rhs),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // monitors see pre-edge values
    always @(posedge clk)
    begin
        cell_t c;
        row_t  r;
        if (rst_n && in_valid && !in_stall)
        begin
            c.kind = cell_kind;
            c.rho = density;
            c.cp = heat_capacity;
            c.kp = conductivity_here;
            c.kl = conductivity_left;
            c.kr = conductivity_right;
            c.temp = previous_temp;
            sb.note_cell(c);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r.lower = lower_coef;
            r.diag = diag_coef;
            r.upper = upper_coef;
            r.rhs = rhs;
            sb.check_row(r);
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int n;
        bit held;
        held = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (want_hold && !held)
            begin
                out_stall <= 1'b1;
                for (n = 0; n < 400; n++)
                    @(posedge clk);
                held = 1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_cell(cell_t c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cell_kind <= c.kind;
        density <= c.rho;
        heat_capacity <= c.cp;
        conductivity_here <= c.kp;
        conductivity_left <= c.kl;
        conductivity_right <= c.kr;
        previous_temp <= c.temp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [VW-2:0] pick_mag();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return (VW-1)'({$urandom, $urandom});
            default: return (VW-1)'($urandom_range(0, 32'h0800_0000));
        endcase
    endfunction

    function automatic logic signed [VW-1:0] pick_temp();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(VW-1){1'b0}}};
            1: return {1'b0, {(VW-1){1'b1}}};
            2, 3: return VW'({$urandom, $urandom});
            default: return $signed({16'd0, $urandom_range(0, 32'h4000_0000)})
                            - 48'sh2000_0000;
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        c.kind = 2'($urandom_range(0, 3));
        c.rho = pick_mag();
        c.cp = pick_mag();
        c.kp = pick_mag();
        c.kl = pick_mag();
        c.kr = pick_mag();
        c.temp = pick_temp();
        return c;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic set_side(int side, logic [1:0] kind, logic [63:0] v, logic [63:0] h);
        reg_write(side == 0 ? hfv_pkg::REG_LEFT_KIND : hfv_pkg::REG_RIGHT_KIND, 64'(kind));
        reg_write(side == 0 ? hfv_pkg::REG_LEFT_VALUE : hfv_pkg::REG_RIGHT_VALUE, v);
        reg_write(side == 0 ? hfv_pkg::REG_LEFT_FILM : hfv_pkg::REG_RIGHT_FILM, h);
    endtask

    initial
    begin
        cell_t c;
        logic [63:0] one;
        sb = new();
        calm = 0;
        want_hold = 0;
        one = 64'd1 << FB;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cell_kind = hfv_pkg::CELL_INTERIOR;
        density = '0;
        heat_capacity = '0;
        conductivity_here = '0;
        conductivity_left = '0;
        conductivity_right = '0;
        previous_temp = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each cell kind, zero conductivity
        set_side(0, hfv_pkg::BC_TEMP, 64'd20 << FB, 64'd0);
        set_side(1, hfv_pkg::BC_CONV, 64'd5 << FB, 64'd3 << FB);
        for (int i = 0; i < 24; i++)
        begin
            c.kind = 2'(i % 4);
            c.rho = (i < 4) ? '0 : (i < 8) ? '1 : (VW-1)'(64'd2 << FB);
            c.cp = (i < 8) ? '1 : (VW-1)'(64'd3 << FB);
            c.kp = (i == 9 || i == 10) ? '0 : (i >= 12 && i < 16) ? '1 : (VW-1)'(one);
            c.kl = (i >= 16 && i < 20) ? '1 : '0;
            c.kr = (i >= 16 && i < 20) ? '0 : '1;
            c.temp = (i % 3 == 0) ? {1'b1, {(VW-1){1'b0}}}
                   : (i % 3 == 1) ? {1'b0, {(VW-1){1'b1}}} : 48'sd0;
            send_cell(c);
        end

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    reg_write(hfv_pkg::REG_CELL_SIZE, one);
                    reg_write(hfv_pkg::REG_TIME_STEP, one);
                    set_side(0, hfv_pkg::BC_FLUX, {$urandom, $urandom}, 64'd0);
                    set_side(1, hfv_pkg::BC_TEMP, {$urandom, $urandom}, 64'd0);
                end
                1:
                begin
                    reg_write(hfv_pkg::REG_CELL_SIZE, 64'd1);
                    reg_write(hfv_pkg::REG_TIME_STEP, {17'd0, {(VW-1){1'b1}}});
                    set_side(0, hfv_pkg::BC_CONV, {$urandom, $urandom}, {$urandom, $urandom});
                    set_side(1, BC_UNUSED, 64'd7 << FB, 64'd0);
                end
                2:
                begin
                    reg_write(hfv_pkg::REG_CELL_SIZE, {17'd0, {(VW-1){1'b1}}});
                    reg_write(hfv_pkg::REG_TIME_STEP, 64'd1);
                    set_side(0, BC_UNUSED, 64'd0, '1);
                    set_side(1, hfv_pkg::BC_FLUX, {16'd0, 1'b1, 47'd0}, 64'd0);
                end
                3:
                begin
                    reg_write(hfv_pkg::REG_CELL_SIZE, 64'd0);
                    reg_write(hfv_pkg::REG_TIME_STEP, 64'd0);
                    set_side(0, hfv_pkg::BC_TEMP, {16'd0, 1'b0, {47{1'b1}}}, 64'd0);
                    set_side(1, hfv_pkg::BC_CONV, {16'hffff, 1'b1, 47'd0},
                             {17'd0, {47{1'b1}}});
                end
                default:
                begin
                    reg_write(hfv_pkg::REG_CELL_SIZE, 64'($urandom_range(1, 32'h0400_0000)));
                    reg_write(hfv_pkg::REG_TIME_STEP, 64'($urandom_range(1, 32'h0400_0000)));
                    set_side(0, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                             64'($urandom_range(0, 32'h1000_0000)));
                    set_side(1, 2'($urandom_range(0, 3)), {$urandom, $urandom},
                             64'($urandom_range(0, 32'h1000_0000)));
                end
            endcase
            if (ph == 4)
                want_hold = 1;
            if (ph == 6)
                calm = 1;
            for (int i = 0; i < 175; i++)
                send_cell(random_cell());
        end

        drain();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hfv_pkg.sv
rtl/hfv_div.sv
rtl/heat_fv_tridiag_row_assembly_top.sv
tb/tb_top.sv
